// ----- rtl/tpd_pkg.sv -----
// ----------------------------------------------------------------------------
// tpd_pkg
// Shared types and constants for the two-phase hold detector.
// ----------------------------------------------------------------------------
package tpd_pkg;

	localparam int TIME_BITS_DEF = 16;

	localparam int unsigned PHASE1_HOLD_RST       = 5000;
	localparam int unsigned PHASE2_HOLD_RST       = 5000;
	localparam int unsigned POLL_INTERVAL_RST     = 10;
	localparam int unsigned FLASH_HALF_PERIOD_RST = 250;

	typedef enum logic [1:0] {
		REG_PHASE1_HOLD       = 2'd0,
		REG_PHASE2_HOLD       = 2'd1,
		REG_POLL_INTERVAL     = 2'd2,
		REG_FLASH_HALF_PERIOD = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_DIV  = 2'd1,
		ST_WAIT = 2'd2
	} tpd_state_t;

	localparam logic CMD_START = 1'b0;

	localparam logic [1:0] COLOR_OFF = 2'd0;
	localparam logic [1:0] COLOR_P1  = 2'd1;
	localparam logic [1:0] COLOR_P2  = 2'd2;

	localparam logic [1:0] DEC_CONTINUE = 2'd0;
	localparam logic [1:0] DEC_SETTINGS = 2'd1;
	localparam logic [1:0] DEC_FULL     = 2'd2;

endpackage

// ----- rtl/two_phase_hold_detector.sv -----
// ----------------------------------------------------------------------------
// two_phase_hold_detector
// Long-press detector with two timed phases, flashing LED and final decision.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   item    | item_valid item_ready cmd key_held       | in
//   result  | res_valid res_ready led_write led_color  | out
//           | done_res decision                        |
//   config  | cfg_valid cfg_ready cfg_index cfg_data   | in
//
// A flashing tick shows its result after a pass through the divider: the
// elapsed phase time is divided by the half period in a restoring divider, one
// quotient bit per cycle over TIME_BITS+1 bits. Other items go from idle
// straight to the wait state, which loads the output register. item_ready stays
// low until the result has moved into the output register, so no new item is
// taken while the last one is in work, and a result still waiting in the output
// register holds the next one back.
// Reset clears the session state and loads the register defaults.
// ----------------------------------------------------------------------------
module two_phase_hold_detector #(
	parameter int TIME_BITS = tpd_pkg::TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  logic                 cmd,
	input  logic                 key_held,
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic                 led_write,
	output logic [1:0]           led_color,
	output logic                 done_res,
	output logic [1:0]           decision,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  tpd_pkg::cfg_reg_t    cfg_index,
	input  logic [TIME_BITS-1:0] cfg_data
);
	import tpd_pkg::*;

	localparam int EW   = TIME_BITS + 1;
	localparam int CNTW = $clog2(EW + 1);

	// configuration
	logic [TIME_BITS-1:0] phase1_hold_q, phase2_hold_q, poll_interval_q, half_period_q;

	// session state
	logic          active_q, sec_q, led_lit_q;
	logic [EW-1:0] elapsed_q;

	// divider
	logic [EW-1:0]        dvd_q;
	logic [TIME_BITS-1:0] rem_q;
	logic [TIME_BITS-1:0] dvs_q;
	logic [CNTW-1:0]      cnt_q;

	// pending result
	logic       p_write_q, p_done_q;
	logic [1:0] p_color_q, p_dec_q;

	// output register
	logic       res_valid_q, led_write_q, done_res_q;
	logic [1:0] led_color_q, decision_q;

	tpd_state_t state_q, state_d;

	logic accept, div_step, res_load;

	// decode of an accepted item
	logic                 n_active, n_sec, n_led, n_write, n_done, n_div;
	logic [1:0]           n_color, n_dec;
	logic [EW-1:0]        n_elapsed, sum;
	logic [EW-1:0]        dur;

	// divider step
	logic [EW-1:0]        trial;
	logic                 ge;
	logic [EW-1:0]        diff;
	logic                 want;

	assign accept    = item_valid && item_ready;
	assign cfg_ready = 1'b1;

	assign sum = elapsed_q + {1'b0, poll_interval_q};
	assign dur = {1'b0, (sec_q ? phase2_hold_q : phase1_hold_q)};

	always_comb begin
		n_active  = active_q;
		n_sec     = sec_q;
		n_led     = led_lit_q;
		n_elapsed = elapsed_q;
		n_write   = 1'b0;
		n_color   = COLOR_OFF;
		n_done    = 1'b0;
		n_dec     = DEC_CONTINUE;
		n_div     = 1'b0;
		if (cmd == CMD_START) begin
			n_active  = 1'b1;
			n_elapsed = '0;
			n_write   = 1'b1;
			if (phase1_hold_q != '0) begin
				n_sec   = 1'b0;
				n_led   = 1'b1;
				n_color = COLOR_P1;
			end else if (phase2_hold_q != '0) begin
				n_sec   = 1'b1;
				n_led   = 1'b1;
				n_color = COLOR_P2;
			end else begin
				n_active = 1'b0;
				n_sec    = 1'b0;
				n_led    = 1'b0;
				n_done   = 1'b1;
				n_dec    = DEC_FULL;
			end
		end else if (active_q) begin
			if (!key_held) begin
				n_active  = 1'b0;
				n_sec     = 1'b0;
				n_led     = 1'b0;
				n_elapsed = '0;
				n_write   = 1'b1;
				n_done    = 1'b1;
				n_dec     = sec_q ? DEC_SETTINGS : DEC_CONTINUE;
			end else if (sum >= dur) begin
				n_elapsed = '0;
				n_write   = 1'b1;
				if (!sec_q && phase2_hold_q != '0) begin
					n_sec   = 1'b1;
					n_led   = 1'b1;
					n_color = COLOR_P2;
				end else begin
					n_active = 1'b0;
					n_sec    = 1'b0;
					n_led    = 1'b0;
					n_done   = 1'b1;
					n_dec    = DEC_FULL;
				end
			end else begin
				n_elapsed = sum;
				n_div     = 1'b1;
			end
		end
	end

	assign trial = {rem_q, dvd_q[EW-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};
	assign want  = !ge;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					state_d = n_div ? ST_DIV : ST_WAIT;
				end
			end
			ST_DIV: begin
				if (cnt_q == CNTW'(1)) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (!res_valid_q || res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		item_ready = 1'b0;
		div_step   = 1'b0;
		res_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: item_ready = 1'b1;
			ST_DIV:  div_step   = 1'b1;
			ST_WAIT: res_load   = !res_valid_q || res_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			phase1_hold_q   <= TIME_BITS'(PHASE1_HOLD_RST);
			phase2_hold_q   <= TIME_BITS'(PHASE2_HOLD_RST);
			poll_interval_q <= TIME_BITS'(POLL_INTERVAL_RST);
			half_period_q   <= TIME_BITS'(FLASH_HALF_PERIOD_RST);
			active_q        <= 1'b0;
			sec_q           <= 1'b0;
			led_lit_q       <= 1'b0;
			elapsed_q       <= '0;
			cnt_q           <= '0;
			res_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_PHASE1_HOLD:       phase1_hold_q   <= cfg_data;
					REG_PHASE2_HOLD:       phase2_hold_q   <= cfg_data;
					REG_POLL_INTERVAL:     poll_interval_q <= cfg_data;
					REG_FLASH_HALF_PERIOD: half_period_q   <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				active_q  <= n_active;
				sec_q     <= n_sec;
				led_lit_q <= n_led;
				elapsed_q <= n_elapsed;
				cnt_q     <= CNTW'(EW);
			end else if (div_step) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1) && want != led_lit_q) begin
					led_lit_q <= want;
				end
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// divider datapath and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			dvd_q     <= sum;
			rem_q     <= '0;
			dvs_q     <= (half_period_q == '0) ? TIME_BITS'(1) : half_period_q;
			p_write_q <= n_write;
			p_color_q <= n_color;
			p_done_q  <= n_done;
			p_dec_q   <= n_dec;
		end else if (div_step) begin
			dvd_q <= {dvd_q[EW-2:0], 1'b0};
			rem_q <= ge ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
			if (cnt_q == CNTW'(1) && want != led_lit_q) begin
				p_write_q <= 1'b1;
				p_color_q <= want ? (sec_q ? COLOR_P2 : COLOR_P1) : COLOR_OFF;
			end
		end
		if (res_load) begin
			led_write_q <= p_write_q;
			led_color_q <= p_color_q;
			done_res_q  <= p_done_q;
			decision_q  <= p_dec_q;
		end
	end

	assign res_valid = res_valid_q;
	assign led_write = led_write_q;
	assign led_color = led_color_q;
	assign done_res  = done_res_q;
	assign decision  = decision_q;

endmodule

// ----- verif/hold_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hold_checker
// Watches the item, result and register channels of the hold detector. Keeps
// its own copy of the timing registers and session state, predicts the LED
// write and decision for every accepted item and compares each accepted
// result with the oldest prediction. Mismatches are counted for the top.
// ----------------------------------------------------------------------------
module hold_checker #(
	parameter int TIME_BITS = tpd_pkg::TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic                 item_ready,
	input  logic                 cmd,
	input  logic                 key_held,
	input  logic                 res_valid,
	input  logic                 res_ready,
	input  logic                 led_write,
	input  logic [1:0]           led_color,
	input  logic                 done_res,
	input  logic [1:0]           decision,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  tpd_pkg::cfg_reg_t    cfg_index,
	input  logic [TIME_BITS-1:0] cfg_data,
	output int                   mismatches,
	output int                   outstanding
);
	import tpd_pkg::*;

	typedef struct packed {
		logic       led_write;
		logic [1:0] led_color;
		logic       done_res;
		logic [1:0] decision;
	} outcome_t;

	logic [TIME_BITS-1:0] phase1_hold;
	logic [TIME_BITS-1:0] phase2_hold;
	logic [TIME_BITS-1:0] poll_interval;
	logic [TIME_BITS-1:0] flash_half;

	logic                 session;
	logic                 second_phase;
	logic                 led_lit;
	logic [TIME_BITS:0]   elapsed;

	outcome_t             outcome_q[$];
	int                   fail_total = 0;
	int                   queued = 0;
	int                   results_seen = 0;

	assign mismatches  = fail_total;
	assign outstanding = queued;

	task automatic end_session(input logic [1:0] dec, inout outcome_t o);
		o.led_write  = 1'b1;
		o.led_color  = COLOR_OFF;
		o.done_res   = 1'b1;
		o.decision   = dec;
		session      = 1'b0;
		second_phase = 1'b0;
		elapsed      = '0;
		led_lit      = 1'b0;
	endtask

	task automatic begin_phase(input logic second, inout outcome_t o);
		logic [TIME_BITS-1:0] dur;
		second_phase = second;
		elapsed      = '0;
		dur          = second ? phase2_hold : phase1_hold;
		// empty first phase falls straight through to the second
		if (dur == '0 && !second) begin
			second_phase = 1'b1;
			dur          = phase2_hold;
		end
		if (dur == '0) begin
			end_session(DEC_FULL, o);
		end else begin
			led_lit     = 1'b1;
			o.led_write = 1'b1;
			o.led_color = second_phase ? COLOR_P2 : COLOR_P1;
		end
	endtask

	task automatic hold_step(input logic c, input logic held, output outcome_t o);
		logic [TIME_BITS-1:0] dur;
		logic [TIME_BITS-1:0] half;
		logic [TIME_BITS:0]   quotient;
		o = '0;
		if (c == CMD_START) begin
			session = 1'b1;
			led_lit = 1'b0;
			begin_phase(1'b0, o);
		end else if (session) begin
			elapsed = elapsed + {1'b0, poll_interval};
			dur     = second_phase ? phase2_hold : phase1_hold;
			if (!held) begin
				end_session(second_phase ? DEC_SETTINGS : DEC_CONTINUE, o);
			end else if (elapsed >= dur) begin
				if (!second_phase)
					begin_phase(1'b1, o);
				else
					end_session(DEC_FULL, o);
			end else begin
				half     = (flash_half == '0) ? TIME_BITS'(1) : flash_half;
				quotient = elapsed / half;
				if ((!quotient[0]) != led_lit) begin
					led_lit     = !quotient[0];
					o.led_write = 1'b1;
					o.led_color = !led_lit ? COLOR_OFF :
						(second_phase ? COLOR_P2 : COLOR_P1);
				end
			end
		end
	endtask

	task automatic flag_failure(input string msg);
		if (fail_total < 10)
			$display("[%0t] %s", $realtime, msg);
		fail_total++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t predicted;
		outcome_t wanted;
		outcome_t got;
		if (!arst_n) begin
			phase1_hold   = TIME_BITS'(PHASE1_HOLD_RST);
			phase2_hold   = TIME_BITS'(PHASE2_HOLD_RST);
			poll_interval = TIME_BITS'(POLL_INTERVAL_RST);
			flash_half    = TIME_BITS'(FLASH_HALF_PERIOD_RST);
			session       = 1'b0;
			second_phase  = 1'b0;
			led_lit       = 1'b0;
			elapsed       = '0;
			outcome_q.delete();
			queued <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PHASE1_HOLD:       phase1_hold   = cfg_data;
					REG_PHASE2_HOLD:       phase2_hold   = cfg_data;
					REG_POLL_INTERVAL:     poll_interval = cfg_data;
					REG_FLASH_HALF_PERIOD: flash_half    = cfg_data;
					default: ;
				endcase
			end
			if (res_valid && res_ready) begin
				got = {led_write, led_color, done_res, decision};
				if (outcome_q.size() == 0) begin
					flag_failure($sformatf(
						"result %0d with nothing pending: write %0b color %0d done %0b dec %0d",
						results_seen, got.led_write, got.led_color, got.done_res,
						got.decision));
				end else begin
					wanted = outcome_q.pop_front();
					if (got.led_write !== wanted.led_write ||
					    got.led_color !== wanted.led_color ||
					    got.done_res  !== wanted.done_res  ||
					    got.decision  !== wanted.decision) begin
						flag_failure($sformatf(
							{"result %0d: expected write %0b color %0d done %0b dec %0d,",
							 " got write %0b color %0d done %0b dec %0d"},
							results_seen, wanted.led_write, wanted.led_color,
							wanted.done_res, wanted.decision, got.led_write,
							got.led_color, got.done_res, got.decision));
					end
				end
				results_seen++;
			end
			if (item_valid && item_ready) begin
				hold_step(cmd, key_held, predicted);
				outcome_q.push_back(predicted);
			end
			queued <= outcome_q.size();
		end
	end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the two-phase hold detector. A short directed run covers idle
// ticks, restarts, releases in both phases, empty phases and the extreme
// register values; then random timing settings are programmed in turn and
// hold sessions with random length and release point are played against
// them, with bursty item traffic and a stalling result receiver.
// ----------------------------------------------------------------------------
module tb_top;
	import tpd_pkg::*;

	localparam int TB_TIME_BITS = TIME_BITS_DEF;
	localparam logic CMD_TICK = ~CMD_START;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    item_valid;
	logic                    item_ready;
	logic                    cmd;
	logic                    key_held;
	logic                    res_valid;
	logic                    res_ready = 1'b0;
	logic                    led_write;
	logic [1:0]              led_color;
	logic                    done_res;
	logic [1:0]              decision;
	logic                    cfg_valid;
	logic                    cfg_ready;
	cfg_reg_t                cfg_index;
	logic [TB_TIME_BITS-1:0] cfg_data;

	int fail_count;
	int outstanding;
	int burst_left = 0;
	int stall_left = 0;
	int stall_mode = 0;

	two_phase_hold_detector #(.TIME_BITS(TB_TIME_BITS)) uut (.*);

	hold_checker #(.TIME_BITS(TB_TIME_BITS)) chk (
		.*,
		.mismatches (fail_count),
		.outstanding(outstanding)
	);

	always #6 clk = ~clk;

	// receiver changes its stall habit every so often
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(16, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0:       res_ready <= 1'b1;
			1:       res_ready <= 1'($urandom_range(0, 1));
			2:       res_ready <= ($urandom_range(0, 3) == 0);
			default: res_ready <= ($urandom_range(0, 7) != 0);
		endcase
	end

	task automatic drive_item(input logic c, input logic held);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		item_valid <= 1'b1;
		cmd        <= c;
		key_held   <= held;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		burst_left--;
	endtask

	task automatic start_hold();
		drive_item(CMD_START, 1'($urandom_range(0, 1)));
	endtask

	task automatic tick(input logic held);
		drive_item(CMD_TICK, held);
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [TB_TIME_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic program_timings(input int h1, input int h2, input int poll, input int half);
		drain_results();
		write_reg(REG_PHASE1_HOLD, TB_TIME_BITS'(h1));
		write_reg(REG_PHASE2_HOLD, TB_TIME_BITS'(h2));
		write_reg(REG_POLL_INTERVAL, TB_TIME_BITS'(poll));
		write_reg(REG_FLASH_HALF_PERIOD, TB_TIME_BITS'(half));
		cfg_valid <= 1'b0;
	endtask

	function automatic int pick_time(input int typical_max);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 0;
		if (r == 1)
			return 65535;
		return $urandom_range(1, typical_max);
	endfunction

	// one session: maybe idle ticks, start, ticks held, maybe a release somewhere
	task automatic play_session(input int h1, input int h2, input int poll, output int counted);
		int est;
		int n;
		int release_at;
		int i;
		int idle;
		idle = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
		repeat (idle) tick(1'($urandom_range(0, 1)));
		est = (poll == 0) ? 12 : (h1 + h2) / poll + 2;
		if (est > 60)
			est = 60;
		n          = $urandom_range(0, est + 3);
		release_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n) : n + 1;
		start_hold();
		for (i = 0; i < n; i++)
			tick(i != release_at);
		counted = 1 + idle + n;
	endtask

	initial begin
		int spent;
		int phase_target;
		int phase_count;
		int counted;
		int h1;
		int h2;
		int poll;
		int half;
		arst_n     = 1'b0;
		item_valid = 1'b0;
		cmd        = CMD_START;
		key_held   = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = REG_PHASE1_HOLD;
		cfg_data   = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// register defaults: idle ticks, release, restart
		tick(1'b1);
		tick(1'b0);
		start_hold();
		tick(1'b1);
		tick(1'b0);
		start_hold();
		start_hold();
		tick(1'b0);

		// fast flashing through both phases, released in the second
		program_timings(30, 30, 5, 10);
		start_hold();
		repeat (8) tick(1'b1);
		tick(1'b0);

		// both phases empty
		program_timings(0, 0, 10, 250);
		start_hold();

		// empty first phase, held through the second
		program_timings(0, 20, 10, 65535);
		start_hold();
		tick(1'b1);
		tick(1'b1);

		// widest values, each phase passes in one tick
		program_timings(65535, 65535, 65535, 0);
		start_hold();
		tick(1'b1);
		tick(1'b1);

		// time stands still, only a release ends it
		program_timings(20, 0, 0, 1);
		start_hold();
		tick(1'b1);
		tick(1'b0);

		spent = 0;
		while (spent < 600) begin
			h1   = pick_time(400);
			h2   = pick_time(400);
			poll = pick_time(40);
			half = pick_time(50);
			program_timings(h1, h2, poll, half);
			phase_target = $urandom_range(30, 80);
			phase_count  = 0;
			while (phase_count < phase_target) begin
				play_session(h1, h2, poll, counted);
				phase_count += counted;
			end
			spent += phase_count;
		end

		drain_results();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
